// File: sv/otsl_pkg.sv
// Shared types, widths and constants of the offset target step limiter.
// No dependencies; every other file of the block imports this package.
package otsl_pkg;

	localparam int AXES      = 3;
	localparam int POS_W     = 32;             // Q15.16 position
	localparam int Q_FRAC    = 16;
	localparam int MS_W      = 31;             // max step register
	localparam int Q_W       = 17;             // quality, Q1.16
	localparam int CFG_IDX_W = 3;

	localparam int TGT_W  = POS_W + 1;         // magnet plus offset
	localparam int DIF_W  = POS_W + 2;         // signed displacement
	localparam int MAG_W  = POS_W + 1;         // displacement magnitude
	localparam int SQR_W  = 2 * MAG_W;
	localparam int PROD_W = MAG_W + MS_W;

	// integer square root unit
	localparam int SQ_IN_W   = 72;
	localparam int SQ_OUT_W  = SQ_IN_W / 2;
	localparam int SQ_REM_W  = SQ_OUT_W + 2;
	localparam int SQ_SIDE_W = AXES * (POS_W + TGT_W + DIF_W);

	// long division unit
	localparam int DV_LANES  = AXES;
	localparam int DV_NUM_W  = PROD_W + 1;
	localparam int DV_DEN_W  = SQ_OUT_W;
	localparam int DV_Q_W    = MS_W;
	localparam int DV_REM_W  = DV_DEN_W + 1;
	localparam int DV_SIDE_W = AXES * (POS_W + TGT_W) + AXES + 1;

	localparam logic [POS_W-1:0]    OFFSET_Z_RST = POS_W'(3277);   // 0.05 m
	localparam logic [MS_W-1:0]     MAX_STEP_RST = MS_W'(1311);    // 0.02 m
	localparam logic [DV_DEN_W-1:0] ONE_Q16      = DV_DEN_W'(1) << Q_FRAC;
	localparam logic [DV_NUM_W-1:0] ONE_Q32      = DV_NUM_W'(1) << (2 * Q_FRAC);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_X,
		REG_OFFSET_Y,
		REG_OFFSET_Z,
		REG_MAX_STEP,
		REG_READY_CFG
	} reg_idx_t;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef struct packed {
		pos_t magnet_x;
		pos_t magnet_y;
		pos_t magnet_z;
		pos_t sensor_x;
		pos_t sensor_y;
		pos_t sensor_z;
	} in_item_t;

	typedef struct packed {
		pos_t           target_x;
		pos_t           target_y;
		pos_t           target_z;
		logic [Q_W-1:0] quality;
		logic           valid_res;
	} out_item_t;

	// square of the magnitude of a signed displacement
	function automatic logic [SQR_W-1:0] sq_mag(input logic signed [DIF_W-1:0] d);
		logic [MAG_W-1:0] m;
		logic [SQR_W-1:0] p;
		m = d[DIF_W-1] ? MAG_W'(-d) : MAG_W'(d);
		p = m * m;
		return p;
	endfunction

	// clamp to the signed position range
	function automatic logic [POS_W-1:0] sat_pos(input logic signed [DIF_W-1:0] v);
		logic [POS_W-1:0] r;
		if ((&v[DIF_W-1:POS_W-1]) || !(|v[DIF_W-1:POS_W-1])) begin
			r = v[POS_W-1:0];
		end else if (v[DIF_W-1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: sv/otsl_in_if.sv
// Input channel of the offset target step limiter: valid/ready plus one pose item.
// Depends on otsl_pkg for the item type.
interface otsl_in_if
	import otsl_pkg::*;
;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/otsl_out_if.sv
// Output channel of the offset target step limiter: valid/ready plus one result item.
// Depends on otsl_pkg for the item type.
interface otsl_out_if
	import otsl_pkg::*;
;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/otsl_sqrt.sv
// Pipelined integer square root, one result bit per register stage, with sideband.
// Depends on otsl_pkg for widths.
module otsl_sqrt
	import otsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [SQ_IN_W-1:0]   in_rad,
	input  logic [SQ_SIDE_W-1:0] in_side,
	output logic                 out_valid,
	output logic [SQ_OUT_W-1:0]  out_root,
	output logic [SQ_SIDE_W-1:0] out_side
);

	logic                 vld_s  [SQ_OUT_W];
	logic [SQ_IN_W-1:0]   rad_s  [SQ_OUT_W];
	logic [SQ_REM_W-1:0]  rem_s  [SQ_OUT_W];
	logic [SQ_OUT_W-1:0]  root_s [SQ_OUT_W];
	logic [SQ_SIDE_W-1:0] side_s [SQ_OUT_W];

	for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_stage
		logic                 v_i;
		logic [SQ_IN_W-1:0]   rad_i;
		logic [SQ_REM_W-1:0]  rem_i;
		logic [SQ_OUT_W-1:0]  root_i;
		logic [SQ_SIDE_W-1:0] side_i;
		logic [SQ_REM_W-1:0]  rem_sh;
		logic [SQ_REM_W-1:0]  trial;
		logic                 ge;

		if (k == 0) begin : g_head
			assign v_i    = in_valid;
			assign rad_i  = in_rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_body
			assign v_i    = vld_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_sh = {rem_i[SQ_REM_W-3:0], rad_i[SQ_IN_W-1 -: 2]};
		assign trial  = {root_i, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[k]  <= rad_i << 2;
				rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {root_i[SQ_OUT_W-2:0], ge};
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[SQ_OUT_W-1];
	assign out_root  = root_s[SQ_OUT_W-1];
	assign out_side  = side_s[SQ_OUT_W-1];

endmodule

// File: sv/otsl_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per register stage.
// Depends on otsl_pkg; the caller guarantees the quotient fits DV_Q_W bits.
module otsl_div
	import otsl_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic [DV_LANES-1:0][DV_NUM_W-1:0]  in_num,
	input  logic [DV_LANES-1:0][DV_DEN_W-1:0]  in_den,
	input  logic [DV_SIDE_W-1:0]               in_side,
	output logic                               out_valid,
	output logic [DV_LANES-1:0][DV_Q_W-1:0]    out_quo,
	output logic [DV_SIDE_W-1:0]               out_side
);

	logic                              vld_s  [DV_Q_W];
	logic [DV_LANES-1:0][DV_REM_W-1:0] rem_s  [DV_Q_W];
	logic [DV_LANES-1:0][DV_Q_W-1:0]   lo_s   [DV_Q_W];
	logic [DV_LANES-1:0][DV_DEN_W-1:0] den_s  [DV_Q_W];
	logic [DV_LANES-1:0][DV_Q_W-1:0]   quo_s  [DV_Q_W];
	logic [DV_SIDE_W-1:0]              side_s [DV_Q_W];

	for (genvar k = 0; k < DV_Q_W; k++) begin : g_stage
		logic                              v_i;
		logic [DV_LANES-1:0][DV_REM_W-1:0] rem_i;
		logic [DV_LANES-1:0][DV_Q_W-1:0]   lo_i;
		logic [DV_LANES-1:0][DV_DEN_W-1:0] den_i;
		logic [DV_LANES-1:0][DV_Q_W-1:0]   quo_i;
		logic [DV_SIDE_W-1:0]              side_i;
		logic [DV_LANES-1:0][DV_REM_W-1:0] rem_n;
		logic [DV_LANES-1:0]               ge;

		if (k == 0) begin : g_head
			always_comb begin
				for (int l = 0; l < DV_LANES; l++) begin
					rem_i[l] = DV_REM_W'(in_num[l][DV_NUM_W-1:DV_Q_W]);
					lo_i[l]  = in_num[l][DV_Q_W-1:0];
				end
			end
			assign v_i    = in_valid;
			assign den_i  = in_den;
			assign quo_i  = '0;
			assign side_i = in_side;
		end else begin : g_body
			assign v_i    = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign lo_i   = lo_s[k-1];
			assign den_i  = den_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_comb begin
			logic [DV_REM_W-1:0] rsh;
			for (int l = 0; l < DV_LANES; l++) begin
				rsh      = {rem_i[l][DV_REM_W-2:0], lo_i[l][DV_Q_W-1]};
				ge[l]    = rsh >= DV_REM_W'(den_i[l]);
				rem_n[l] = ge[l] ? rsh - DV_REM_W'(den_i[l]) : rsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < DV_LANES; l++) begin
					rem_s[k][l] <= rem_n[l];
					lo_s[k][l]  <= lo_i[l] << 1;
					quo_s[k][l] <= {quo_i[l][DV_Q_W-2:0], ge[l]};
				end
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[DV_Q_W-1];
	assign out_quo   = quo_s[DV_Q_W-1];
	assign out_side  = side_s[DV_Q_W-1];

endmodule

// File: sv/otsl_outq.sv
// Two-entry output queue that decouples the pipeline from the result channel.
// Depends on otsl_pkg and otsl_out_if.
module otsl_outq
	import otsl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  out_item_t         push_item,
	output logic              space,
	otsl_out_if.source        out_ch
);

	out_item_t  ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign space        = cnt_q != 2'd2;
	assign push         = push_valid && space;
	assign pop          = out_ch.valid && out_ch.ready;
	assign out_ch.valid = cnt_q != 2'd0;
	assign out_ch.data  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

endmodule

// File: sv/offset_target_step_limiter.sv
// Top level of the offset target step limiter: config registers, pipeline stages,
// two square root units, two divider units and the output queue. Depends on otsl_pkg.
//
// Takes one pose transaction per clock while the pipeline advances, and returns one
// result transaction per input, in order, through the two 36-stage square root units
// and the two 31-stage dividers, each producing one bit per stage, and the output
// queue. The whole pipeline advances together; it holds only when the two-entry
// output queue is full, so the input keeps being accepted while one finished result
// waits on the output. The user must write configuration (offsets, max_step,
// ready_cfg) through the cfg port only while no transaction is in flight; the block
// does not enforce it. When ready_cfg is 0 every result is all zero with valid_res low.
module offset_target_step_limiter
	import otsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [POS_W-1:0]     cfg_data,
	otsl_in_if.sink              in_ch,
	otsl_out_if.source           out_ch
);

	// configuration
	logic [AXES-1:0][POS_W-1:0] off_q;
	logic [MS_W-1:0]            max_step_q;
	logic                       ready_cfg_q;

	// global advance: the pipeline moves whenever the output queue has room
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q[0]    <= '0;
			off_q[1]    <= '0;
			off_q[2]    <= OFFSET_Z_RST;
			max_step_q  <= MAX_STEP_RST;
			ready_cfg_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_OFFSET_X:  off_q[0]    <= cfg_data;
				REG_OFFSET_Y:  off_q[1]    <= cfg_data;
				REG_OFFSET_Z:  off_q[2]    <= cfg_data;
				REG_MAX_STEP:  max_step_q  <= cfg_data[MS_W-1:0];
				REG_READY_CFG: ready_cfg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = adv;

	// ---- S1: ideal target and displacement from the sensor
	logic [AXES-1:0][POS_W-1:0] mag_in, sen_in;
	logic [AXES-1:0][TGT_W-1:0] t_n;
	logic [AXES-1:0][DIF_W-1:0] d_n;
	logic                       v_s1;
	logic [AXES-1:0][POS_W-1:0] s_s1;
	logic [AXES-1:0][TGT_W-1:0] t_s1;
	logic [AXES-1:0][DIF_W-1:0] d_s1;

	always_comb begin
		mag_in = {in_ch.data.magnet_z, in_ch.data.magnet_y, in_ch.data.magnet_x};
		sen_in = {in_ch.data.sensor_z, in_ch.data.sensor_y, in_ch.data.sensor_x};
		for (int a = 0; a < AXES; a++) begin
			t_n[a] = TGT_W'($signed(mag_in[a])) + TGT_W'($signed(off_q[a]));
			d_n[a] = DIF_W'($signed(t_n[a])) - DIF_W'($signed(sen_in[a]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1 <= sen_in;
			t_s1 <= t_n;
			d_s1 <= d_n;
		end
	end

	// ---- S2: squares of the displacement
	logic                       v_s2;
	logic [AXES-1:0][POS_W-1:0] s_s2;
	logic [AXES-1:0][TGT_W-1:0] t_s2;
	logic [AXES-1:0][DIF_W-1:0] d_s2;
	logic [AXES-1:0][SQR_W-1:0] sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				sq_s2[a] <= sq_mag($signed(d_s1[a]));
			end
			s_s2 <= s_s1;
			t_s2 <= t_s1;
			d_s2 <= d_s1;
		end
	end

	// ---- S3: sum of squares
	logic                 v_s3;
	logic [SQ_IN_W-1:0]   rad_s3;
	logic [SQ_SIDE_W-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3  <= SQ_IN_W'(sq_s2[0]) + SQ_IN_W'(sq_s2[1]) + SQ_IN_W'(sq_s2[2]);
			side_s3 <= {s_s2, t_s2, d_s2};
		end
	end

	// ---- distance to the ideal target
	logic                       v_r1;
	logic [SQ_OUT_W-1:0]        root_r1;
	logic [SQ_SIDE_W-1:0]       side_r1;
	logic [AXES-1:0][POS_W-1:0] s_r1;
	logic [AXES-1:0][TGT_W-1:0] t_r1;
	logic [AXES-1:0][DIF_W-1:0] d_r1;

	otsl_sqrt u_sqrt_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s3),
		.in_rad    (rad_s3),
		.in_side   (side_s3),
		.out_valid (v_r1),
		.out_root  (root_r1),
		.out_side  (side_r1)
	);

	assign {s_r1, t_r1, d_r1} = side_r1;

	// ---- S4: limit decision and |d| * max_step
	logic [AXES-1:0][MAG_W-1:0]  dmag_n;
	logic                        v_s4;
	logic [AXES-1:0][PROD_W-1:0] prod_s4;
	logic [SQ_OUT_W-1:0]         dist_s4;
	logic                        lim_s4;
	logic [AXES-1:0]             neg_s4;
	logic [AXES-1:0][POS_W-1:0]  s_s4;
	logic [AXES-1:0][TGT_W-1:0]  t_s4;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			dmag_n[a] = d_r1[a][DIF_W-1] ? MAG_W'(-$signed(d_r1[a])) : MAG_W'(d_r1[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_r1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				prod_s4[a] <= dmag_n[a] * max_step_q;
				neg_s4[a]  <= d_r1[a][DIF_W-1];
			end
			dist_s4 <= root_r1;
			lim_s4  <= root_r1 > SQ_OUT_W'(max_step_q);
			s_s4    <= s_r1;
			t_s4    <= t_r1;
		end
	end

	// ---- S5: add half the divisor for round-to-nearest
	logic                                v_s5;
	logic [DV_LANES-1:0][DV_NUM_W-1:0]   num_s5;
	logic [DV_LANES-1:0][DV_DEN_W-1:0]   den_s5;
	logic [DV_SIDE_W-1:0]                side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				num_s5[a] <= DV_NUM_W'(prod_s4[a]) + DV_NUM_W'(dist_s4 >> 1);
				den_s5[a] <= dist_s4;
			end
			side_s5 <= {s_s4, t_s4, neg_s4, lim_s4};
		end
	end

	// ---- scale each component by max_step / distance (only used when limiting)
	logic                               v_q1;
	logic [DV_LANES-1:0][DV_Q_W-1:0]    quo_q1;
	logic [DV_SIDE_W-1:0]               side_q1;
	logic [AXES-1:0][POS_W-1:0]         s_q1;
	logic [AXES-1:0][TGT_W-1:0]         t_q1;
	logic [AXES-1:0]                    neg_q1;
	logic                               lim_q1;

	otsl_div u_div_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s5),
		.in_num    (num_s5),
		.in_den    (den_s5),
		.in_side   (side_s5),
		.out_valid (v_q1),
		.out_quo   (quo_q1),
		.out_side  (side_q1)
	);

	assign {s_q1, t_q1, neg_q1, lim_q1} = side_q1;

	// ---- S6: pick limited or ideal target, saturate
	logic [AXES-1:0][POS_W-1:0] tgt_n;
	logic                       v_s6;
	logic [AXES-1:0][POS_W-1:0] tgt_s6;
	logic [AXES-1:0][POS_W-1:0] s_s6;

	always_comb begin
		logic signed [DIF_W-1:0] qe;
		logic signed [DIF_W-1:0] tn;
		for (int a = 0; a < AXES; a++) begin
			qe = DIF_W'(quo_q1[a]);
			if (lim_q1) begin
				tn = DIF_W'($signed(s_q1[a])) + (neg_q1[a] ? -qe : qe);
			end else begin
				tn = DIF_W'($signed(t_q1[a]));
			end
			tgt_n[a] = sat_pos(tn);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_q1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tgt_s6 <= tgt_n;
			s_s6   <= s_q1;
		end
	end

	// ---- S7: remaining displacement to the saturated target
	logic                       v_s7;
	logic [AXES-1:0][POS_W-1:0] tgt_s7;
	logic [AXES-1:0][DIF_W-1:0] d2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				d2_s7[a] <= DIF_W'($signed(tgt_s6[a])) - DIF_W'($signed(s_s6[a]));
			end
			tgt_s7 <= tgt_s6;
		end
	end

	// ---- S8: squares of the remaining displacement
	logic                       v_s8;
	logic [AXES-1:0][POS_W-1:0] tgt_s8;
	logic [AXES-1:0][SQR_W-1:0] sq2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				sq2_s8[a] <= sq_mag($signed(d2_s7[a]));
			end
			tgt_s8 <= tgt_s7;
		end
	end

	// ---- S9: sum of squares
	logic                 v_s9;
	logic [SQ_IN_W-1:0]   rad2_s9;
	logic [SQ_SIDE_W-1:0] side2_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad2_s9  <= SQ_IN_W'(sq2_s8[0]) + SQ_IN_W'(sq2_s8[1]) + SQ_IN_W'(sq2_s8[2]);
			side2_s9 <= SQ_SIDE_W'(tgt_s8);
		end
	end

	// ---- remaining distance
	logic                 v_r2;
	logic [SQ_OUT_W-1:0]  root_r2;
	logic [SQ_SIDE_W-1:0] side_r2;

	otsl_sqrt u_sqrt_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s9),
		.in_rad    (rad2_s9),
		.in_side   (side2_s9),
		.out_valid (v_r2),
		.out_root  (root_r2),
		.out_side  (side_r2)
	);

	// ---- S10: quality numerator and denominator, 2^32 + den/2 over 1.0 + distance
	logic [DV_DEN_W-1:0]              qden_n;
	logic                             v_s10;
	logic [DV_LANES-1:0][DV_NUM_W-1:0] num2_s10;
	logic [DV_LANES-1:0][DV_DEN_W-1:0] den2_s10;
	logic [DV_SIDE_W-1:0]             side_s10;

	assign qden_n = root_r2 + ONE_Q16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= v_r2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num2_s10[0] <= ONE_Q32 + DV_NUM_W'(qden_n >> 1);
			den2_s10[0] <= qden_n;
			// park the spare lanes at zero
			for (int a = 1; a < DV_LANES; a++) begin
				num2_s10[a] <= '0;
				den2_s10[a] <= '0;
			end
			side_s10    <= DV_SIDE_W'(side_r2[AXES*POS_W-1:0]);
		end
	end

	// ---- quality division (lane 0 only)
	logic                            v_q2;
	logic [DV_LANES-1:0][DV_Q_W-1:0] quo_q2;
	logic [DV_SIDE_W-1:0]            side_q2;
	logic [AXES-1:0][POS_W-1:0]      tgt_q2;
	out_item_t                       res;

	otsl_div u_div_quality (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s10),
		.in_num    (num2_s10),
		.in_den    (den2_s10),
		.in_side   (side_s10),
		.out_valid (v_q2),
		.out_quo   (quo_q2),
		.out_side  (side_q2)
	);

	assign tgt_q2 = side_q2[AXES*POS_W-1:0];

	// zero the whole result when the block has not been set up
	always_comb begin
		if (ready_cfg_q) begin
			res.target_x  = tgt_q2[0];
			res.target_y  = tgt_q2[1];
			res.target_z  = tgt_q2[2];
			res.quality   = quo_q2[0][Q_W-1:0];
			res.valid_res = 1'b1;
		end else begin
			res = '0;
		end
	end

	otsl_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (v_q2),
		.push_item  (res),
		.space      (adv),
		.out_ch     (out_ch)
	);

endmodule
